[rtl/pvp_pkg.sv]
// Shared types, constants and the vertex table function for the polygon vertex projector.
`timescale 1ns / 1ps
`default_nettype none
package pvp_pkg;

    localparam int COEF_W     = 21;
    localparam int CFG_W      = 63;
    localparam int CFG_ADDR_W = 3;
    localparam int WIN_W      = 12;
    localparam int SCR_W      = 16;
    localparam int VNUM_W     = 5;
    localparam int QBITS      = 16;

    localparam int TRI_SIDES  = 3;
    localparam int QUAD_SIDES = 4;
    localparam int PENT_SIDES = 5;

    localparam logic [WIN_W-1:0] WIN_W_RESET = 12'd800;
    localparam logic [WIN_W-1:0] WIN_H_RESET = 12'd600;

    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_COL_X = 3'd0,
        CFG_COL_Y = 3'd1,
        CFG_COL_W = 3'd2,
        CFG_WIN_W = 3'd3,
        CFG_WIN_H = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SHAPE_TRI    = 2'd0,
        SHAPE_QUAD   = 2'd1,
        SHAPE_PENT   = 2'd2,
        SHAPE_CIRCLE = 2'd3
    } shape_t;

    typedef enum logic {
        SEQ_IDLE = 1'b0,
        SEQ_RUN  = 1'b1
    } seq_state_t;

    // Sideband that travels with each vertex down the pipe.
    typedef struct packed {
        logic              valid;
        logic              zero;
        logic [VNUM_W-1:0] vnum;
        logic              last;
    } vtx_tag_t;

    // Halve a Q30 value and round to frac bits, half away from zero.
    function automatic longint half_to_q(longint v, int frac);
        longint m;
        int     sh;
        sh = 31 - frac;
        m  = (v < 0) ? -v : v;
        m  = (m + (64'sd1 <<< (sh - 1))) >>> sh;
        return (v < 0) ? -m : m;
    endfunction

    // Unit-circle vertex at angle ang (full turn = 2^32), radius 0.5.
    // Only evaluated on constants to build the vertex tables.
    function automatic logic [127:0] unit_vertex(logic [31:0] ang, int frac);
        longint unsigned u;
        longint x, x2, t, s, c, cs, sn;
        logic [1:0] q;
        q  = ang[31:30];
        u  = 64'(ang[29:0]);
        u  = (u * 64'(HALF_PI_Q30)) >> 30;
        x  = longint'(u);
        x2 = (x * x) >>> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 110;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 72;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 42;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 20;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 6;
        s  = (x * t) >>> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 132;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 90;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 56;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 30;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 12;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 2;
        c  = t;
        case (q)
            2'd0: begin cs = c;  sn = s;  end
            2'd1: begin cs = -s; sn = c;  end
            2'd2: begin cs = -c; sn = -s; end
            default: begin cs = s; sn = -c; end
        endcase
        return {half_to_q(cs, frac), half_to_q(sn, frac)};
    endfunction

endpackage
`default_nettype wire

[rtl/pvp_vertex_gen.sv]
// Shape sequencer and local vertex lookup: one vertex per enabled cycle.
`timescale 1ns / 1ps
`default_nettype none
module pvp_vertex_gen #(
    parameter int MAX_SIDES = 32,
    parameter int FRAC_BITS = 16,
    localparam int VW       = FRAC_BITS + 2,
    localparam int CNT_W    = $clog2(MAX_SIDES)
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire pvp_pkg::shape_t      s_kind,
    output logic signed [VW-1:0]      v_x,
    output logic signed [VW-1:0]      v_y,
    output pvp_pkg::vtx_tag_t         v_tag
);
    import pvp_pkg::*;

    localparam logic signed [VW-1:0] HALF = VW'(1) <<< (FRAC_BITS - 1);

    logic signed [VW-1:0] circ_x [MAX_SIDES];
    logic signed [VW-1:0] circ_y [MAX_SIDES];
    logic signed [VW-1:0] tri_x  [TRI_SIDES];
    logic signed [VW-1:0] tri_y  [TRI_SIDES];
    logic signed [VW-1:0] pent_x [PENT_SIDES];
    logic signed [VW-1:0] pent_y [PENT_SIDES];

    seq_state_t        state_reg, state_next;
    shape_t            kind_reg, kind_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  last_idx;
    logic              is_last;
    logic              issue;
    logic signed [VW-1:0] vx_sel, vy_sel;
    logic signed [VW-1:0] vx_reg, vy_reg;
    vtx_tag_t          tag_reg;

    for (genvar j = 0; j < MAX_SIDES; j++) begin : g_circ
        localparam logic [63:0]  JS  = 64'(j) << 32;
        localparam logic [31:0]  ANG = 32'h4000_0000 + 32'(JS / MAX_SIDES);
        localparam logic [127:0] V   = unit_vertex(ANG, FRAC_BITS);
        assign circ_x[j] = V[64 +: VW];
        assign circ_y[j] = V[0 +: VW];
    end

    for (genvar j = 0; j < TRI_SIDES; j++) begin : g_tri
        localparam logic [63:0]  JS  = 64'(j) << 32;
        localparam logic [31:0]  ANG = 32'h4000_0000 + 32'(JS / TRI_SIDES);
        localparam logic [127:0] V   = unit_vertex(ANG, FRAC_BITS);
        assign tri_x[j] = V[64 +: VW];
        assign tri_y[j] = V[0 +: VW];
    end

    for (genvar j = 0; j < PENT_SIDES; j++) begin : g_pent
        localparam logic [63:0]  JS  = 64'(j) << 32;
        localparam logic [31:0]  ANG = 32'h4000_0000 + 32'(JS / PENT_SIDES);
        localparam logic [127:0] V   = unit_vertex(ANG, FRAC_BITS);
        assign pent_x[j] = V[64 +: VW];
        assign pent_y[j] = V[0 +: VW];
    end

    always_comb begin
        case (kind_reg)
            SHAPE_TRI:  last_idx = CNT_W'(TRI_SIDES - 1);
            SHAPE_QUAD: last_idx = CNT_W'(QUAD_SIDES - 1);
            SHAPE_PENT: last_idx = CNT_W'(PENT_SIDES - 1);
            default:    last_idx = CNT_W'(MAX_SIDES - 1);
        endcase
    end

    assign is_last = (cnt_reg == last_idx);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE: if (s_valid) begin
                state_next = SEQ_RUN;
            end
            SEQ_RUN: if (en && is_last) begin
                state_next = SEQ_IDLE;
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready = 1'b0;
        issue   = 1'b0;
        case (state_reg)
            SEQ_IDLE: s_ready = 1'b1;
            SEQ_RUN:  issue   = en;
            default: begin
                s_ready = 1'b0;
                issue   = 1'b0;
            end
        endcase
    end

    always_comb begin
        kind_next = kind_reg;
        cnt_next  = cnt_reg;
        if (s_valid && s_ready) begin
            kind_next = s_kind;
            cnt_next  = '0;
        end else if (issue) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_comb begin
        case (kind_reg)
            SHAPE_TRI: begin
                vx_sel = tri_x[cnt_reg[1:0]];
                vy_sel = tri_y[cnt_reg[1:0]];
            end
            SHAPE_QUAD: begin
                vx_sel = (cnt_reg == CNT_W'(0) || cnt_reg == CNT_W'(3)) ? HALF : -HALF;
                vy_sel = (cnt_reg < CNT_W'(2)) ? HALF : -HALF;
            end
            SHAPE_PENT: begin
                vx_sel = pent_x[cnt_reg[2:0]];
                vy_sel = pent_y[cnt_reg[2:0]];
            end
            default: begin
                vx_sel = circ_x[cnt_reg];
                vy_sel = circ_y[cnt_reg];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_IDLE;
            kind_reg  <= SHAPE_TRI;
            cnt_reg   <= '0;
            tag_reg   <= '0;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            cnt_reg   <= cnt_next;
            if (en) begin
                // valid, zero, vnum, last
                tag_reg <= {(state_reg == SEQ_RUN), 1'b0, VNUM_W'(cnt_reg), is_last};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vx_reg <= vx_sel;
            vy_reg <= vy_sel;
        end
    end

    assign v_x   = vx_reg;
    assign v_y   = vy_reg;
    assign v_tag = tag_reg;

endmodule
`default_nettype wire

[rtl/pvp_transform.sv]
// Matrix transform and viewport numerators: four pipeline stages.
`timescale 1ns / 1ps
`default_nettype none
module pvp_transform #(
    parameter int FRAC_BITS = 16,
    localparam int VW       = FRAC_BITS + 2,
    localparam int PROD_W   = pvp_pkg::COEF_W + VW,
    localparam int CLIP_W   = PROD_W + 2,
    localparam int SUM_W    = CLIP_W + 1,
    localparam int NUM_W    = SUM_W + pvp_pkg::WIN_W + 1,
    localparam int DEN_W    = CLIP_W + 1
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire logic signed [VW-1:0]        in_x,
    input  wire logic signed [VW-1:0]        in_y,
    input  wire pvp_pkg::vtx_tag_t           in_tag,
    input  wire logic [pvp_pkg::CFG_W-1:0]   col_x,
    input  wire logic [pvp_pkg::CFG_W-1:0]   col_y,
    input  wire logic [pvp_pkg::CFG_W-1:0]   col_w,
    input  wire logic [pvp_pkg::WIN_W-1:0]   win_w,
    input  wire logic [pvp_pkg::WIN_W-1:0]   win_h,
    output logic signed [NUM_W-1:0]          num_x,
    output logic signed [NUM_W-1:0]          num_y,
    output logic signed [DEN_W-1:0]          den,
    output pvp_pkg::vtx_tag_t                out_tag
);
    import pvp_pkg::*;

    logic signed [COEF_W-1:0] m [9];
    logic signed [PROD_W-1:0] prod_reg [9];
    logic signed [CLIP_W-1:0] cx_reg, cy_reg, cw_reg;
    logic signed [SUM_W-1:0]  sx_reg, sy_reg;
    logic signed [DEN_W-1:0]  d_reg, den_reg;
    logic signed [NUM_W-1:0]  nx_reg, ny_reg;
    logic signed [WIN_W:0]    ww, wh;
    vtx_tag_t                 t2_reg, t3_reg, t4_reg, t5_reg;

    // slot 0: x term, slot 1: y term, slot 2: constant term
    for (genvar s = 0; s < 3; s++) begin : g_coef
        assign m[s]     = $signed(col_x[s*COEF_W +: COEF_W]);
        assign m[3 + s] = $signed(col_y[s*COEF_W +: COEF_W]);
        assign m[6 + s] = $signed(col_w[s*COEF_W +: COEF_W]);
    end

    assign ww = $signed({1'b0, win_w});
    assign wh = $signed({1'b0, win_h});

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                prod_reg[3*r]     <= m[3*r] * in_x;
                prod_reg[3*r + 1] <= m[3*r + 1] * in_y;
                prod_reg[3*r + 2] <= PROD_W'(m[3*r + 2]) <<< FRAC_BITS;
            end
            cx_reg <= CLIP_W'(prod_reg[0]) + CLIP_W'(prod_reg[1]) + CLIP_W'(prod_reg[2]);
            cy_reg <= CLIP_W'(prod_reg[3]) + CLIP_W'(prod_reg[4]) + CLIP_W'(prod_reg[5]);
            cw_reg <= CLIP_W'(prod_reg[6]) + CLIP_W'(prod_reg[7]) + CLIP_W'(prod_reg[8]);
            sx_reg <= SUM_W'(cx_reg) + SUM_W'(cw_reg);
            sy_reg <= SUM_W'(cw_reg) - SUM_W'(cy_reg);
            d_reg  <= {cw_reg, 1'b0};
            nx_reg  <= sx_reg * ww;
            ny_reg  <= sy_reg * wh;
            den_reg <= d_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t2_reg <= '0;
            t3_reg <= '0;
            t4_reg <= '0;
            t5_reg <= '0;
        end else if (en) begin
            t2_reg <= in_tag;
            t3_reg <= t2_reg;
            // zero flag joins here, alongside the clip w of this vertex
            t4_reg <= {t3_reg.valid, (cw_reg == '0), t3_reg.vnum, t3_reg.last};
            t5_reg <= t4_reg;
        end
    end

    assign num_x   = nx_reg;
    assign num_y   = ny_reg;
    assign den     = den_reg;
    assign out_tag = t5_reg;

endmodule
`default_nettype wire

[rtl/pvp_div.sv]
// Pipelined restoring divider, two numerator lanes over one shared divisor.
`timescale 1ns / 1ps
`default_nettype none
module pvp_div #(
    parameter int NUM_W = 55,
    parameter int DEN_W = 42,
    localparam int CW   = DEN_W + pvp_pkg::QBITS + 1
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic signed [NUM_W-1:0]      num_x,
    input  wire logic signed [NUM_W-1:0]      num_y,
    input  wire logic signed [DEN_W-1:0]      den,
    input  wire pvp_pkg::vtx_tag_t            in_tag,
    output logic [pvp_pkg::QBITS-1:0]         q_x,
    output logic [pvp_pkg::QBITS-1:0]         q_y,
    output logic [1:0]                        neg,
    output logic [1:0]                        big,
    output pvp_pkg::vtx_tag_t                 out_tag
);
    import pvp_pkg::*;

    logic [NUM_W-1:0]  a_reg   [2];
    logic [1:0]        na_reg;
    logic [DEN_W-1:0]  b_reg;
    vtx_tag_t          ta_reg;

    // stage 0 holds the overflow check, stage s resolves quotient bit QBITS-s
    logic [NUM_W-1:0]  rem_reg  [2][QBITS+1];
    logic [NUM_W-1:0]  rem_next [2][QBITS+1];
    logic [QBITS-1:0]  q_reg    [2][QBITS+1];
    logic [QBITS-1:0]  q_next   [2][QBITS+1];
    logic [1:0]        neg_reg  [QBITS+1];
    logic [1:0]        big_reg  [QBITS+1];
    logic [1:0]        big0;
    logic [DEN_W-1:0]  bs_reg   [QBITS+1];
    vtx_tag_t          tag_reg  [QBITS+1];
    logic [NUM_W-1:0]  num_abs  [2];
    logic [NUM_W-1:0]  num_in   [2];
    logic [CW-1:0]     dsub;

    assign num_in[0] = num_x;
    assign num_in[1] = num_y;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            num_abs[l] = num_in[l][NUM_W-1] ? NUM_W'(-num_in[l]) : num_in[l];
            big0[l]    = CW'(a_reg[l]) >= (CW'(b_reg) << QBITS);
        end
    end

    always_comb begin
        dsub = '0;
        for (int l = 0; l < 2; l++) begin
            rem_next[l][0] = a_reg[l];
            q_next[l][0]   = '0;
        end
        for (int s = 1; s <= QBITS; s++) begin
            for (int l = 0; l < 2; l++) begin
                dsub = CW'(bs_reg[s-1]) << (QBITS - s);
                if (CW'(rem_reg[l][s-1]) >= dsub) begin
                    rem_next[l][s] = NUM_W'(CW'(rem_reg[l][s-1]) - dsub);
                    q_next[l][s]   = q_reg[l][s-1] | (QBITS'(1) << (QBITS - s));
                end else begin
                    rem_next[l][s] = rem_reg[l][s-1];
                    q_next[l][s]   = q_reg[l][s-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg[0] <= num_abs[0];
            a_reg[1] <= num_abs[1];
            na_reg   <= {num_y[NUM_W-1] ^ den[DEN_W-1], num_x[NUM_W-1] ^ den[DEN_W-1]};
            b_reg    <= den[DEN_W-1] ? DEN_W'(-den) : den;
            for (int s = 0; s <= QBITS; s++) begin
                for (int l = 0; l < 2; l++) begin
                    rem_reg[l][s] <= rem_next[l][s];
                    q_reg[l][s]   <= q_next[l][s];
                end
            end
            neg_reg[0] <= na_reg;
            big_reg[0] <= big0;
            bs_reg[0]  <= b_reg;
            for (int s = 1; s <= QBITS; s++) begin
                neg_reg[s] <= neg_reg[s-1];
                big_reg[s] <= big_reg[s-1];
                bs_reg[s]  <= bs_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ta_reg <= '0;
            for (int s = 0; s <= QBITS; s++) begin
                tag_reg[s] <= '0;
            end
        end else if (en) begin
            ta_reg     <= in_tag;
            tag_reg[0] <= ta_reg;
            for (int s = 1; s <= QBITS; s++) begin
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    assign q_x     = q_reg[0][QBITS];
    assign q_y     = q_reg[1][QBITS];
    assign neg     = neg_reg[QBITS];
    assign big     = big_reg[QBITS];
    assign out_tag = tag_reg[QBITS];

endmodule
`default_nettype wire

[rtl/polygon_vertex_projector_core.sv]
// Top level of the polygon vertex projector: config registers, pipeline, output register.
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tdata[1:0] shape_kind
//  m_       out  m_tvalid/m_tready  m_tdata x,y,vertex_number; m_tlast; m_tuser clipped
//  cfg_     in   cfg_wr_en          cfg_addr, cfg_wdata
//
// A request of n vertices holds s_tready low until its last vertex has entered
// the pipe, one vertex per cycle unless the output stalls; the next request
// is taken the cycle after. Between vertex issue and m_tvalid lie the lookup,
// four transform stages, abs, 17 divider stages and the output register.
// Reset is synchronous; all stages hold together while m_tvalid is high and m_tready low.
`timescale 1ns / 1ps
`default_nettype none
module polygon_vertex_projector_core #(
    parameter int MAX_SIDES = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,   // [1:0] shape_kind
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [39:0]                             m_tdata,   // screen_x, screen_y, vertex_number
    output logic                                    m_tlast,
    output logic [0:0]                              m_tuser,   // clipped
    input  wire logic                               cfg_wr_en,
    input  wire logic [pvp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [pvp_pkg::CFG_W-1:0]          cfg_wdata
);
    import pvp_pkg::*;

    localparam int VW     = FRAC_BITS + 2;
    localparam int CLIP_W = COEF_W + VW + 2;
    localparam int NUM_W  = CLIP_W + 1 + WIN_W + 1;
    localparam int DEN_W  = CLIP_W + 1;

    logic [CFG_W-1:0] col_x_reg, col_y_reg, col_w_reg;
    logic [WIN_W-1:0] win_w_reg, win_h_reg;

    logic                    en;
    logic signed [VW-1:0]    v_x, v_y;
    vtx_tag_t                v_tag;
    logic signed [NUM_W-1:0] num_x, num_y;
    logic signed [DEN_W-1:0] den;
    vtx_tag_t                t_tag, d_tag;
    logic [QBITS-1:0]        q [2];
    logic [1:0]              neg, big;
    logic [SCR_W-1:0]        scr [2];
    logic [1:0]              sat;

    logic                    out_valid_reg;
    logic [SCR_W-1:0]        sx_reg, sy_reg;
    logic [VNUM_W-1:0]       vnum_reg;
    logic                    last_reg, clip_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_x_reg <= '0;
            col_y_reg <= '0;
            col_w_reg <= '0;
            win_w_reg <= WIN_W_RESET;
            win_h_reg <= WIN_H_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                CFG_COL_X: col_x_reg <= cfg_wdata;
                CFG_COL_Y: col_y_reg <= cfg_wdata;
                CFG_COL_W: col_w_reg <= cfg_wdata;
                CFG_WIN_W: win_w_reg <= cfg_wdata[WIN_W-1:0];
                CFG_WIN_H: win_h_reg <= cfg_wdata[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign en = !out_valid_reg || m_tready;

    pvp_vertex_gen #(
        .MAX_SIDES (MAX_SIDES),
        .FRAC_BITS (FRAC_BITS)
    ) u_gen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_kind  (shape_t'(s_tdata[1:0])),
        .v_x     (v_x),
        .v_y     (v_y),
        .v_tag   (v_tag)
    );

    pvp_transform #(
        .FRAC_BITS (FRAC_BITS)
    ) u_xform (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_x    (v_x),
        .in_y    (v_y),
        .in_tag  (v_tag),
        .col_x   (col_x_reg),
        .col_y   (col_y_reg),
        .col_w   (col_w_reg),
        .win_w   (win_w_reg),
        .win_h   (win_h_reg),
        .num_x   (num_x),
        .num_y   (num_y),
        .den     (den),
        .out_tag (t_tag)
    );

    pvp_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .num_x   (num_x),
        .num_y   (num_y),
        .den     (den),
        .in_tag  (t_tag),
        .q_x     (q[0]),
        .q_y     (q[1]),
        .neg     (neg),
        .big     (big),
        .out_tag (d_tag)
    );

    // sign, clamp to 16 bits; w == 0 forces zero
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            sat[l] = 1'b0;
            if (d_tag.zero) begin
                scr[l] = '0;
            end else if (big[l]) begin
                sat[l] = 1'b1;
                scr[l] = neg[l] ? 16'h8000 : 16'h7FFF;
            end else if (neg[l]) begin
                if (q[l] > 16'h8000) begin
                    sat[l] = 1'b1;
                    scr[l] = 16'h8000;
                end else begin
                    scr[l] = 16'(0 - q[l]);
                end
            end else if (q[l] > 16'h7FFF) begin
                sat[l] = 1'b1;
                scr[l] = 16'h7FFF;
            end else begin
                scr[l] = q[l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= d_tag.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sx_reg   <= scr[0];
            sy_reg   <= scr[1];
            vnum_reg <= d_tag.vnum;
            last_reg <= d_tag.last;
            clip_reg <= d_tag.zero | sat[0] | sat[1];
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {3'b000, vnum_reg, sy_reg, sx_reg};
    assign m_tlast    = last_reg;
    assign m_tuser[0] = clip_reg;

`ifndef SYNTHESIS
    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sequencer took a request but stayed ready");

    a_last_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tdata[36:32] == 5'(TRI_SIDES - 1) ||
                                 m_tdata[36:32] == 5'(QUAD_SIDES - 1) ||
                                 m_tdata[36:32] == 5'(PENT_SIDES - 1) ||
                                 m_tdata[36:32] == 5'(MAX_SIDES - 1)))
        else $error("last vertex flagged at a wrong vertex number");

    a_pipe_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(v_tag) && $stable(d_tag))
        else $error("pipeline moved during an output stall");
`endif

endmodule
`default_nettype wire
